// ===== src/lprl_pkg.sv =====
`timescale 1ns / 1ps

package lprl_pkg;

	localparam int ADDR_W  = 32;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int LEN_W   = 6;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
	} route_entry_t;

	// Count the one bits of a mask with a five-level pairwise reduction.
	function automatic logic [LEN_W-1:0] mask_len(input logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] t;
		t = v - ((v >> 1) & 32'h5555_5555);
		t = (t & 32'h3333_3333) + ((t >> 2) & 32'h3333_3333);
		t = (t + (t >> 4)) & 32'h0F0F_0F0F;
		t = t + (t >> 8);
		t = t + (t >> 16);
		return t[LEN_W-1:0];
	endfunction

endpackage

// ===== src/longest_prefix_route_lookup_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// ---------------------------------------------------------------------------
// in        sink       in_valid / in_ready   req_type, entry_index,
//                                            route_prefix_in, route_mask_in,
//                                            dest_addr
// out       source     out_valid / out_ready hit, route_index
// cfg       sink       cfg_wr_en (no wait)   cfg_wr_data (route_count)
//
// A write request produces no result; writes can stream back to back.
// With N = min(route_count, TABLE_DEPTH), a lookup drops in_ready while it scans N entries:
// one entry read per cycle, then compare, best-match update and output stages.
// The result appears at the edge where in_ready returns; the output register lets the next
// request transfer while out_ready is low, and a second result holds until the first one goes.
// Reset clears control state and route_count; the table is undefined until written.

module longest_prefix_route_lookup_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [lprl_pkg::IDX_W-1:0]   entry_index,
	input  logic [lprl_pkg::ADDR_W-1:0]  route_prefix_in,
	input  logic [lprl_pkg::ADDR_W-1:0]  route_mask_in,
	input  logic [lprl_pkg::ADDR_W-1:0]  dest_addr,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [lprl_pkg::IDX_W-1:0]   route_index,

	input  logic                         cfg_wr_en,
	input  logic [lprl_pkg::CNT_W-1:0]   cfg_wr_data
);

	import lprl_pkg::*;

	// Table address width and a scan counter wide enough to hold the depth.
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   route_count_q;

	// Route table: one write port, one registered read port.
	route_entry_t       table_mem [TABLE_DEPTH];

	logic [CW-1:0]      limit_q;
	logic [CW-1:0]      issue_cnt_q;
	logic [ADDR_W-1:0]  dest_q;

	// Read stage.
	logic               rd_vld_s1;
	route_entry_t       rd_data_s1;
	logic [AW-1:0]      rd_idx_s1;

	// Compare stage.
	logic               vld_s2;
	logic               match_s2;
	logic [LEN_W-1:0]   len_s2;
	logic [AW-1:0]      idx_s2;

	// Best match so far.
	logic               found_q;
	logic [LEN_W-1:0]   best_len_q;
	logic [AW-1:0]      best_idx_q;

	// Output register.
	logic               out_valid_q;
	logic               hit_q;
	logic [IDX_W-1:0]   route_index_q;

	logic               in_xfer;
	logic               wr_req;
	logic               lookup_req;
	logic [31:0]        wr_idx_ext;
	logic               wr_in_range;
	logic [31:0]        rc_ext;
	logic [CW-1:0]      limit_d;
	logic               issue_now;
	logic               scan_done;
	logic               better;
	logic [31:0]        best_idx_ext;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_xfer     = in_valid && in_ready;
	assign wr_req      = in_xfer && (req_type == REQ_WRITE);
	assign lookup_req  = in_xfer && (req_type == REQ_LOOKUP);

	// Drop writes to slots beyond the table.
	assign wr_idx_ext  = 32'(entry_index);
	assign wr_in_range = (wr_idx_ext < 32'(TABLE_DEPTH));

	// Saturate the route count to the table depth for the scan.
	assign rc_ext  = 32'(route_count_q);
	assign limit_d = (rc_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(rc_ext);

	assign issue_now = (state_q == ST_SCAN) && (issue_cnt_q < limit_q);
	assign scan_done = (issue_cnt_q == limit_q) && !rd_vld_s1 && !vld_s2;

	// Strictly longer wins, so the lowest index keeps a tie.
	assign better = match_s2 && (!found_q || (len_s2 > best_len_q));

	assign best_idx_ext = 32'(best_idx_q);

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign route_index = route_index_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (cfg_wr_en) begin
			route_count_q <= cfg_wr_data;
		end
	end

	// Table write and entry read.
	always_ff @(posedge clk) begin
		if (wr_req && wr_in_range) begin
			table_mem[wr_idx_ext[AW-1:0]] <= '{prefix: route_prefix_in, mask: route_mask_in};
		end
		if (issue_now) begin
			rd_data_s1 <= table_mem[issue_cnt_q[AW-1:0]];
		end
	end

	// Datapath registers: capture the destination, then compare and measure.
	always_ff @(posedge clk) begin
		if (lookup_req) begin
			dest_q <= dest_addr;
		end
		if (issue_now) begin
			rd_idx_s1 <= issue_cnt_q[AW-1:0];
		end
		match_s2 <= rd_vld_s1 &&
			((dest_q & rd_data_s1.mask) == (rd_data_s1.prefix & rd_data_s1.mask));
		len_s2   <= mask_len(rd_data_s1.mask);
		idx_s2   <= rd_idx_s1;
	end

	// Sequencer, best-match tracking and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			limit_q       <= '0;
			issue_cnt_q   <= '0;
			rd_vld_s1     <= 1'b0;
			vld_s2        <= 1'b0;
			found_q       <= 1'b0;
			best_len_q    <= '0;
			best_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			route_index_q <= '0;
		end else begin
			rd_vld_s1 <= issue_now;
			vld_s2    <= rd_vld_s1;

			// Retire the held result once it transfers, unless a new one replaces it.
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (lookup_req) begin
						limit_q     <= limit_d;
						issue_cnt_q <= '0;
						found_q     <= 1'b0;
						best_len_q  <= '0;
						best_idx_q  <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_now) begin
						issue_cnt_q <= issue_cnt_q + CW'(1);
					end
					if (better) begin
						found_q    <= 1'b1;
						best_len_q <= len_s2;
						best_idx_q <= idx_s2;
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hold until the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						hit_q         <= found_q;
						route_index_q <= found_q ? best_idx_ext[IDX_W-1:0] : '0;
						state_q       <= ST_IDLE;
					end else begin
						out_valid_q   <= out_valid_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
